### src/ilq_pkg.sv
`default_nettype none

package ilq_pkg;

   // Number of identifier slots; identifiers 0 .. CAPACITY-1 are valid.
   localparam int CAPACITY = 256;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // A link is a slot number with one extra bit; the top bit set means nil.
   localparam int LINK_W   = SLOT_W + 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int ID_W     = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;

   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(1) << SLOT_W;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [LINK_W-1:0] link_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 2'd0,
      KIND_PEEK   = 2'd1,
      KIND_POP    = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_INVALID   = 3'd2,
      STATUS_DUPLICATE = 3'd3,
      STATUS_EMPTY     = 3'd4,
      STATUS_NOT_FOUND = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_PUSH2,
      S_UNLINK,
      S_DONE
   } state_type;

   // Access bundle for the link RAM: one read port, one write port per array.
   typedef struct packed {
      logic     rd_en;
      slot_type rd_addr;
      logic     prev_we;
      slot_type prev_addr;
      link_type prev_data;
      logic     next_we;
      slot_type next_addr;
      link_type next_data;
   } ram_req_type;

   function automatic logic link_ok(input link_type l);
      return !l[LINK_W-1];
   endfunction

   function automatic link_type to_link(input slot_type s);
      return {1'b0, s};
   endfunction

endpackage

`default_nettype wire

### src/indexed_linked_queue_unit.sv
`default_nettype none

// Indexed linked queue: a FIFO of identifiers kept as a doubly linked list,
// one fixed slot per identifier, so any queued identifier can be unlinked
// from the middle in constant time.
// Request channel (req_*): tuser carries the operation (push, peek head,
// pop head, remove), tdata the identifier. Response channel (rsp_*): one
// transaction per request with status, head identifier and count.
// Timing: one request at a time. An accepted request passes S_CHECK and then
// S_DONE for peek, failed requests and push to an empty queue; push behind
// an existing tail passes S_CHECK, S_PUSH2 and S_DONE, and pop and remove
// pass S_CHECK, S_UNLINK and S_DONE. The next request is accepted in S_IDLE
// once S_DONE has issued the response. Push behind a tail needs S_PUSH2 since
// the new slot's next link and the old tail's next link share the single write
// port of the next-link array. Pop and remove need S_UNLINK for the synchronous
// read of the slot's links before writing the neighbors.
// The response sits in an output register; the next request is accepted
// while it waits, and the unit holds its finished result until the register
// is free, so a stalled receiver backpressures after one request in flight.
// Reset empties the queue: occupied marks are flip-flops that clear at once;
// link RAM contents are only read for occupied slots.
module indexed_linked_queue_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [15:0] entry_id
   input  wire  [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata    // [2:0] status, [18:3] head_id, [34:19] count
);
   import ilq_pkg::*;

   state_type           state_ff, state_in;
   kind_type            kind_ff, kind_in;
   logic [ID_W-1:0]     id_ff, id_in;
   status_type          status_ff, status_in;
   link_type            head_out_ff, head_out_in;
   link_type            head_ff, head_in;
   link_type            tail_ff, tail_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [CAPACITY-1:0] occ_ff, occ_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [39:0]         rsp_data_ff, rsp_data_in;

   ram_req_type         ram_req;
   link_type            rd_prev, rd_next;

   slot_type            slot;
   logic                id_bad;
   logic                q_empty;
   logic [ID_W-1:0]     head_id_ext;

   ilq_link_ram u_link_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_prev (rd_prev),
      .rd_next (rd_next)
   );

   assign slot    = id_ff[SLOT_W-1:0];
   assign id_bad  = id_ff >= ID_W'(CAPACITY);
   assign q_empty = count_ff == '0;
   assign head_id_ext = head_out_ff[LINK_W-1] ? '0 : ID_W'(head_out_ff);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      status_in    = status_ff;
      head_out_in  = head_out_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      ram_req      = '0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in  = kind_type'(req_tuser);
               id_in    = req_tdata;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            status_in   = STATUS_OK;
            head_out_in = NIL_LINK;
            state_in    = S_DONE;
            case (kind_ff)
               KIND_PUSH: begin
                  if (count_ff == COUNT_W'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else if (id_bad) begin
                     status_in = STATUS_INVALID;
                  end else if (occ_ff[slot]) begin
                     status_in = STATUS_DUPLICATE;
                  end else begin
                     ram_req.prev_we   = 1'b1;
                     ram_req.prev_addr = slot;
                     ram_req.prev_data = tail_ff;
                     ram_req.next_we   = 1'b1;
                     if (link_ok(tail_ff)) begin
                        // old tail points forward to the new slot; the new
                        // slot's own next link follows in the next cycle
                        ram_req.next_addr = tail_ff[SLOT_W-1:0];
                        ram_req.next_data = to_link(slot);
                        state_in          = S_PUSH2;
                     end else begin
                        ram_req.next_addr = slot;
                        ram_req.next_data = NIL_LINK;
                        head_in           = to_link(slot);
                     end
                     tail_in      = to_link(slot);
                     occ_in[slot] = 1'b1;
                     count_in     = count_ff + 1'b1;
                  end
               end
               KIND_PEEK: begin
                  if (q_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     head_out_in = head_ff;
                  end
               end
               KIND_POP: begin
                  if (q_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     head_out_in     = head_ff;
                     id_in           = ID_W'(head_ff[SLOT_W-1:0]);
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = head_ff[SLOT_W-1:0];
                     state_in        = S_UNLINK;
                  end
               end
               KIND_REMOVE: begin
                  if (q_empty) begin
                     status_in = STATUS_EMPTY;
                  end else if (id_bad) begin
                     status_in = STATUS_INVALID;
                  end else if (!occ_ff[slot]) begin
                     status_in = STATUS_NOT_FOUND;
                  end else begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = slot;
                     state_in        = S_UNLINK;
                  end
               end
               default: begin
                  status_in = STATUS_INVALID;
               end
            endcase
         end

         S_PUSH2: begin
            ram_req.next_we   = 1'b1;
            ram_req.next_addr = slot;
            ram_req.next_data = NIL_LINK;
            state_in          = S_DONE;
         end

         S_UNLINK: begin
            // rd_prev / rd_next hold the links of the slot being detached
            if (link_ok(rd_prev)) begin
               ram_req.next_we   = 1'b1;
               ram_req.next_addr = rd_prev[SLOT_W-1:0];
               ram_req.next_data = rd_next;
            end else begin
               head_in = rd_next;
            end
            if (link_ok(rd_next)) begin
               ram_req.prev_we   = 1'b1;
               ram_req.prev_addr = rd_next[SLOT_W-1:0];
               ram_req.prev_data = rd_prev;
            end else begin
               tail_in = rd_prev;
            end
            occ_in[slot] = 1'b0;
            count_in     = count_ff - 1'b1;
            state_in     = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, ID_W'(count_ff), head_id_ext, status_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL_LINK;
         tail_ff      <= NIL_LINK;
         count_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      status_ff   <= status_in;
      head_out_ff <= head_out_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // count never exceeds the number of slots
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("queue count beyond capacity");

   // an empty queue has nil head and tail; a non-empty one has real slots
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (!link_ok(head_ff) && !link_ok(tail_ff)))
      else $error("empty queue with live head or tail");

   a_live_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (link_ok(head_ff) && link_ok(tail_ff)))
      else $error("non-empty queue with nil head or tail");

   // occupied marks track the count
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_ff) == int'(count_ff))
      else $error("occupied marks disagree with count");

endmodule

`default_nettype wire

### src/ilq_link_ram.sv
`default_nettype none

module ilq_link_ram (
   input  wire                       clock,
   input  ilq_pkg::ram_req_type      ram_req,
   output ilq_pkg::link_type         rd_prev,
   output ilq_pkg::link_type         rd_next
);
   import ilq_pkg::*;

   // Links of a slot are only read while the slot is occupied, so no reset.
   link_type prev_mem [CAPACITY];
   link_type next_mem [CAPACITY];
   link_type rd_prev_ff;
   link_type rd_next_ff;

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_prev_ff <= prev_mem[ram_req.rd_addr];
         rd_next_ff <= next_mem[ram_req.rd_addr];
      end
      if (ram_req.prev_we) begin
         prev_mem[ram_req.prev_addr] <= ram_req.prev_data;
      end
      if (ram_req.next_we) begin
         next_mem[ram_req.next_addr] <= ram_req.next_data;
      end
   end

   assign rd_prev = rd_prev_ff;
   assign rd_next = rd_next_ff;

endmodule

`default_nettype wire
